>>> rtl/core/bts_pkg.sv
// Shared types, widths and register codes for the bounded toggle selection set.
package bts_pkg;

  // Fixed field widths of the words on the channels
  localparam int ITEM_W = 16;
  localparam int CNT_W  = 5;
  localparam int CFG_W  = 5;

  // Default sizing handed to the top level
  localparam int DEF_DEPTH      = 16;
  localparam int DEF_INDEX_BITS = 16;

  // Configuration register indexes
  localparam logic CFG_MAX_ENTRIES = 1'b0;
  localparam logic CFG_DESELECT    = 1'b1;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 5'd16;
  localparam logic             DESELECT_RST    = 1'b0;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } bts_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;  // take input word, register match flags
    logic commit;   // apply list update and load the result register
  } bts_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free; // result register empty or being taken this cycle
  } bts_sts_t;

endpackage

>>> rtl/core/bts_ifs.sv
// Valid/ready channel interfaces for the request and result words.
interface bts_req_if;
  logic                         valid;
  logic                         ready;
  logic [bts_pkg::ITEM_W-1:0]   item_index;

  modport source (output valid, output item_index, input ready);
  modport sink   (input valid, input item_index, output ready);
endinterface

interface bts_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         newly_selected;
  logic [bts_pkg::CNT_W-1:0]    entry_count;

  modport source (output valid, output newly_selected, output entry_count, input ready);
  modport sink   (input valid, input newly_selected, input entry_count, output ready);
endinterface

>>> rtl/core/bts_ctrl.sv
// Controller: sequences the match cycle and the update cycle of each word.
module bts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bts_pkg::bts_sts_t sts_i,
  output bts_pkg::bts_cmd_t cmd_o
);
  import bts_pkg::*;

  bts_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_UPDATE: begin
        cmd_o.commit = sts_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/bts_dp.sv
// Datapath: entry list, parallel match, shift/append update and result register.
module bts_dp #(
  parameter int DEPTH      = bts_pkg::DEF_DEPTH,
  parameter int INDEX_BITS = bts_pkg::DEF_INDEX_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [bts_pkg::CFG_W-1:0]  cfg_data_i,
  // request word
  input  logic [bts_pkg::ITEM_W-1:0] item_index_i,
  // result word
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       newly_selected_o,
  output logic [bts_pkg::CNT_W-1:0]  entry_count_o,
  // control
  input  bts_pkg::bts_cmd_t          cmd_i,
  output bts_pkg::bts_sts_t          sts_o
);
  import bts_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > CFG_W) ? CW : CFG_W;
  localparam int XW = 32;

  // Configuration registers
  logic [CFG_W-1:0] max_entries_q;
  logic             deselect_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= MAX_ENTRIES_RST;
      deselect_q    <= DESELECT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_ENTRIES: max_entries_q <= cfg_data_i;
        CFG_DESELECT:    deselect_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // List state
  logic [INDEX_BITS-1:0] entry_q [DEPTH];
  logic [CW-1:0]         count_q, count_d;
  logic [DEPTH-1:0]      match_q, match_d;
  logic [INDEX_BITS-1:0] idx_q;
  logic [XW-1:0]         idx_ext;
  logic [INDEX_BITS-1:0] idx_in;

  // High bits beyond INDEX_BITS are dropped
  assign idx_ext = {{(XW-ITEM_W){1'b0}}, item_index_i};
  assign idx_in  = idx_ext[INDEX_BITS-1:0];

  // Update decision
  logic          found, remove, evict;
  logic [LW-1:0] max_ext, lim, cnt_ext, count_ext_d;
  logic [CW-1:0] app_pos;
  logic [DEPTH-1:0] shift_en;

  assign found   = |match_q;
  assign max_ext = LW'(max_entries_q);
  assign cnt_ext = LW'(count_q);

  // Effective limit: zero acts as one, above depth acts as depth
  always_comb begin
    priority if (max_ext == '0)          lim = LW'(1);
    else if     (max_ext > LW'(DEPTH))   lim = LW'(DEPTH);
    else                                 lim = max_ext;
  end

  assign remove  = found && deselect_q;
  assign evict   = !found && (cnt_ext >= lim);
  assign app_pos = evict ? (count_q - CW'(1)) : count_q;

  always_comb begin
    priority if (remove)     count_d = count_q - CW'(1);
    else if     (found)      count_d = count_q;
    else if     (evict)      count_d = count_q;
    else                     count_d = count_q + CW'(1);
  end

  assign count_ext_d = LW'(count_d);

  // One cell per position: match compare and shift/append
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    // Valid position holding the incoming index
    assign match_d[i] = (CW'(i) < count_q) && (entry_q[i] == idx_in);

    // Positions at or after the removed entry move down one, and all do on an eviction
    assign shift_en[i] = (remove && (|match_q[i:0])) || evict;

    if (i < DEPTH - 1) begin : g_mid
      always_ff @(posedge clk_i) begin
        if (cmd_i.commit) begin
          if (!found && (app_pos == CW'(i))) begin
            entry_q[i] <= idx_q;
          end else if (shift_en[i]) begin
            entry_q[i] <= entry_q[i+1];
          end
        end
      end
    end else begin : g_last
      always_ff @(posedge clk_i) begin
        if (cmd_i.commit && !found && (app_pos == CW'(i))) begin
          entry_q[i] <= idx_q;
        end
      end
    end
  end

  // Capture index and match flags
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      idx_q   <= idx_in;
      match_q <= match_d;
    end
  end

  // Entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit) begin
      count_q <= count_d;
    end
  end

  // Result register
  logic             out_valid_q;
  logic             newly_q;
  logic [CNT_W-1:0] cnt_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.commit || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      newly_q   <= !found;
      cnt_out_q <= count_ext_d[CNT_W-1:0];
    end
  end

  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign newly_selected_o = newly_q;
  assign entry_count_o    = cnt_out_q;

endmodule

>>> rtl/core/bounded_toggle_selection_set.sv
// Top level of the bounded toggle selection set.
// In the accept cycle the index is compared against every held entry in
// parallel and the match flags are registered; in the update state the list
// is shifted or appended and the result word is loaded into the output
// register, waiting while an earlier result is still untaken, so a stalled
// result side slows the rate to one word per result taken. No clearing pass
// follows reset; the block is ready at once. The user must write configuration
// through cfg_we_i/cfg_idx_i/cfg_data_i only while idle; it is not enforced.
module bounded_toggle_selection_set #(
  parameter int DEPTH      = bts_pkg::DEF_DEPTH,
  parameter int INDEX_BITS = bts_pkg::DEF_INDEX_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [bts_pkg::CFG_W-1:0] cfg_data_i,
  bts_req_if.sink                   req_i,
  bts_rsp_if.source                 rsp_o
);
  import bts_pkg::*;

  bts_cmd_t cmd;
  bts_sts_t sts;

  // Sequencer
  bts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // List storage and result register
  bts_dp #(
    .DEPTH      (DEPTH),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .item_index_i     (req_i.item_index),
    .out_valid_o      (rsp_o.valid),
    .out_ready_i      (rsp_o.ready),
    .newly_selected_o (rsp_o.newly_selected),
    .entry_count_o    (rsp_o.entry_count),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the bounded toggle selection set.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bts_pkg::*;

  localparam int DEPTH      = DEF_DEPTH;
  localparam int INDEX_BITS = DEF_INDEX_BITS;
  localparam int N_RANDOM   = 1250;

  // One result word as predicted
  typedef struct packed {
    logic             newly;
    logic [CNT_W-1:0] count;
  } selection_result_t;

  logic             clk_i;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  bts_req_if req ();
  bts_rsp_if rsp ();

  bounded_toggle_selection_set #(
    .DEPTH      (DEPTH),
    .INDEX_BITS (INDEX_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req),
    .rsp_o      (rsp)
  );

  // Words waiting to be offered, and results still owed by the block
  logic [ITEM_W-1:0] pending_items[$];
  selection_result_t expected_results[$];

  // Own copy of the selection list and its settings
  logic [INDEX_BITS-1:0] held_entries[DEPTH];
  int                    held_total  = 0;
  logic [CFG_W-1:0]      limit_reg   = MAX_ENTRIES_RST;
  logic                  deselect_on = DESELECT_RST;

  int  errors        = 0;
  int  results_taken = 0;
  int  send_gap      = 0;
  int  hold_cycles   = 0;
  bit  quiet         = 1'b0;

  // Clock: 4 ns period
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Add a word to the tail of the stimulus queue
  function automatic void queue_word(logic [ITEM_W-1:0] w);
    pending_items.insert(pending_items.size(), w);
  endfunction

  // Add a prediction to the tail of the expected queue
  function automatic void queue_result(selection_result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  // Mostly short gaps, now and then a long one; none in quiet phases
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Remove one held entry and close the gap
  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < held_total; i++) held_entries[i] = held_entries[i + 1];
    if (held_total > 0) held_total--;
  endfunction

  // Predict the result of choosing one index and update the list copy
  function automatic selection_result_t apply_choice(logic [ITEM_W-1:0] word);
    logic [INDEX_BITS-1:0] idx;
    int                    hit;
    int                    lim;
    selection_result_t     res;
    idx = word[INDEX_BITS-1:0];
    hit = -1;
    for (int i = 0; i < held_total; i++) begin
      if (hit < 0 && held_entries[i] == idx) hit = i;
    end
    // zero acts as one, anything above the depth as the depth
    lim = (limit_reg == 0) ? 1 : ((int'(limit_reg) > DEPTH) ? DEPTH : int'(limit_reg));
    if (hit >= 0) begin
      if (deselect_on) drop_entry(hit);
      res.newly = 1'b0;
    end else begin
      // only the single oldest entry goes, even if the limit was lowered
      if (held_total >= lim) drop_entry(0);
      if (held_total < DEPTH) begin
        held_entries[held_total] = idx;
        held_total++;
      end
      res.newly = 1'b1;
    end
    res.count = CNT_W'(held_total);
    return res;
  endfunction

  // Driver: offers queued words, predicts each one as it is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (req.valid && req.ready) queue_result(apply_choice(req.item_index));
      if (!req.valid || req.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          req.valid      <= 1'b1;
          req.item_index <= pending_items.pop_front();
          send_gap = pick_gap();
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result word against the oldest prediction
  always @(posedge clk_i) begin : take_results
    selection_result_t want;
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
      hold_cycles = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        results_taken++;
        if (expected_results.size() == 0) begin
          report_mismatch("result word with none expected, count", rsp.entry_count, -1);
        end else begin
          want = expected_results.pop_front();
          if (rsp.newly_selected !== want.newly)
            report_mismatch("newly_selected", rsp.newly_selected, want.newly);
          if (rsp.entry_count !== want.count)
            report_mismatch("entry_count", rsp.entry_count, want.count);
        end
        // long hold-off so the block fills up and stalls its input
        if (results_taken == 100 || results_taken == 700) hold_cycles = 150;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
        hold_cycles = pick_gap();
      end
    end
  end

  // Register write; the copy follows at once since the block is idle
  task automatic write_register(logic idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MAX_ENTRIES) limit_reg = val;
    else deselect_on = val[0];
  endtask

  // Wait until every word is taken and every result is back
  task automatic settle();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || req.valid || expected_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Stimulus
  initial begin
    int                limit_choices[6];
    int                sent;
    int                phase;
    int                n_items;
    int                lim;
    logic [ITEM_W-1:0] base;

    limit_choices = '{1, 16, 17, 31, 0, 2};
    req.valid      = 1'b0;
    req.item_index = '0;
    rsp.ready      = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_MAX_ENTRIES;
    cfg_data_i     = '0;
    for (int i = 0; i < DEPTH; i++) held_entries[i] = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: extremes of the index, a repeat kept in place
    pending_items = '{16'h0000, 16'hFFFF, 16'h0000};
    settle();

    // Limit of zero acts as one; two held, so the new word only drops the oldest
    write_register(CFG_MAX_ENTRIES, 5'd0);
    write_register(CFG_DESELECT, 5'd1);
    pending_items = '{16'h1234, 16'h1234, 16'h5555};
    settle();

    // Limit above the depth acts as the depth: fill up, then evict
    write_register(CFG_MAX_ENTRIES, 5'd31);
    write_register(CFG_DESELECT, 5'd0);
    for (int i = 0; i < 16; i++) queue_word(16'h8000 >> i);
    queue_word(16'hA5A5);
    settle();

    // Random phases, each with its own settings and a small pool of indices
    sent  = 0;
    phase = 0;
    while (sent < N_RANDOM) begin
      lim = (phase < 6) ? limit_choices[phase] : $urandom_range(0, 31);
      write_register(CFG_MAX_ENTRIES, CFG_W'(lim));
      write_register(CFG_DESELECT, CFG_W'((phase % 3 == 2) ? 0 : $urandom_range(0, 1)));
      quiet   = (phase % 4 == 1);
      n_items = $urandom_range(60, 140);
      base    = ITEM_W'($urandom);
      if (lim == 0) lim = 1;
      if (lim > DEPTH) lim = DEPTH;
      for (int i = 0; i < n_items; i++) begin
        if ($urandom_range(0, 99) < 75)
          queue_word(base + ITEM_W'($urandom_range(0, 2 * lim)));
        else
          queue_word(ITEM_W'($urandom));
      end
      sent += n_items;
      phase++;
      settle();
    end

    quiet = 1'b0;
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
